/* rtl/mbrc_pkg.sv */
// Shared types, constants and helpers for the Modbus RTU response checker.
package mbrc_pkg;

    // Frame length limit and counter width
    localparam int unsigned POS_W = 9;
    localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 9'd256;
    localparam logic [POS_W-1:0] WRITE_FRAME_BYTES = 9'd8;
    localparam logic [POS_W-1:0] MIN_FRAME_BYTES = 9'd3;
    localparam logic [POS_W-1:0] MIN_PDU_FRAME_BYTES = 9'd5;
    localparam logic [POS_W-1:0] PAYLOAD_START = 9'd5;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [6:0] FUNCTION_MASK = 7'd127;

    // Frame status codes
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SHORT      = 4'd1,
        ST_CRC        = 4'd2,
        ST_ADDRESS    = 4'd3,
        ST_PDU_SHORT  = 4'd4,
        ST_FUNCTION   = 4'd5,
        ST_EXCEPTION  = 4'd6,
        ST_UNKNOWN    = 4'd7,
        ST_COUNT      = 4'd8,
        ST_WRITE_SIZE = 4'd9,
        ST_TOO_LONG   = 4'd10
    } t_status;

    // Configuration register contents
    typedef struct packed {
        logic [7:0] slave_address;
        logic [6:0] expected_function;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       frame_done;
        t_status    status;
        logic [7:0] exception_code;
    } t_result;

    function automatic logic is_read_code(input logic [7:0] f);
        return (f == 8'd1) || (f == 8'd2) || (f == 8'd3) || (f == 8'd4) || (f == 8'd23);
    endfunction

    function automatic logic is_write_code(input logic [7:0] f);
        return (f == 8'd5) || (f == 8'd6) || (f == 8'd15) || (f == 8'd16);
    endfunction

endpackage

/* rtl/mbrc_crc.sv */
// Modbus CRC-16 update by one byte (reflected polynomial, eight bit steps).
module mbrc_crc (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import mbrc_pkg::*;

    // Eight shift/xor steps on a 16-bit value
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* rtl/mbrc_regs.sv */
// APB-style configuration registers: slave address and expected function.
module mbrc_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mbrc_pkg::t_cfg     o_cfg
);
    import mbrc_pkg::*;

    localparam logic REG_SLAVE_ADDRESS     = 1'b0;
    localparam logic REG_EXPECTED_FUNCTION = 1'b1;

    logic [7:0] r_slave_address;
    logic [6:0] r_expected_function;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address     <= 8'd1;
            r_expected_function <= 7'd3;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SLAVE_ADDRESS:     r_slave_address     <= pwdata[7:0];
                REG_EXPECTED_FUNCTION: r_expected_function <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[2])
            REG_SLAVE_ADDRESS:     prdata = {24'd0, r_slave_address};
            REG_EXPECTED_FUNCTION: prdata = {25'd0, r_expected_function};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_cfg.slave_address     = r_slave_address;
    assign o_cfg.expected_function = r_expected_function;

endmodule

/* rtl/mbrc_frame.sv */
// Per-frame state (position, CRC, two-byte delay, header bytes) and status decode.
module mbrc_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_end,
    input  mbrc_pkg::t_cfg      i_cfg,
    output mbrc_pkg::t_result   o_result
);
    import mbrc_pkg::*;

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [15:0]      r_crc,   n_crc;
    logic [7:0]       r_older, n_older;
    logic [7:0]       r_newer, n_newer;
    logic [7:0]       r_addr,  n_addr;
    logic [7:0]       r_func,  n_func;
    logic [7:0]       r_cnt,   n_cnt;

    logic [15:0] crc_upd;
    logic        overflow;
    logic [6:0]  fc;
    logic [9:0]  read_len;
    t_status     status;

    mbrc_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (i_rx_byte),
        .o_crc  (crc_upd)
    );

    assign overflow = (r_pos >= MAX_FRAME_BYTES);

    // Frame state advance for this word (before end-of-frame clear)
    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_older = r_older;
        n_newer = r_newer;
        n_addr  = r_addr;
        n_func  = r_func;
        n_cnt   = r_cnt;
        if (!overflow) begin
            n_older = r_newer;
            n_newer = i_rx_byte;
            n_crc   = crc_upd;
            n_pos   = r_pos + 1'b1;
            if (r_pos == 9'd0) n_addr = i_rx_byte;
            if (r_pos == 9'd1) n_func = i_rx_byte;
            if (r_pos == 9'd2) n_cnt  = i_rx_byte;
        end
    end

    assign fc       = n_func[6:0] & FUNCTION_MASK;
    assign read_len = {2'd0, n_cnt} + 10'd5;

    // Status priority chain on the last byte
    always_comb begin
        if (overflow) begin
            status = ST_TOO_LONG;
        end else if (n_pos < MIN_FRAME_BYTES) begin
            status = ST_SHORT;
        end else if (n_crc != 16'd0) begin
            status = ST_CRC;
        end else if (n_addr != i_cfg.slave_address) begin
            status = ST_ADDRESS;
        end else if (n_pos < MIN_PDU_FRAME_BYTES) begin
            status = ST_PDU_SHORT;
        end else if (fc != i_cfg.expected_function) begin
            status = ST_FUNCTION;
        end else if (n_func[7] && (n_cnt != 8'd0)) begin
            status = ST_EXCEPTION;
        end else if (is_read_code({1'b0, fc})) begin
            status = ({1'b0, n_pos} != read_len) ? ST_COUNT : ST_OK;
        end else if (is_write_code({1'b0, fc})) begin
            status = (n_pos != WRITE_FRAME_BYTES) ? ST_WRITE_SIZE : ST_OK;
        end else begin
            status = ST_UNKNOWN;
        end
    end

    // Result word: payload forwarding and end-of-frame status
    always_comb begin
        o_result.data_valid     = !overflow && (r_pos >= PAYLOAD_START) && is_read_code(r_func);
        o_result.data_byte      = o_result.data_valid ? r_older : 8'd0;
        o_result.frame_done     = i_frame_end;
        o_result.status         = i_frame_end ? status : ST_OK;
        o_result.exception_code = (i_frame_end && (status == ST_EXCEPTION)) ? n_cnt : 8'd0;
    end

    // State registers; the last byte returns everything to idle values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= CRC_INIT;
            r_older <= 8'd0;
            r_newer <= 8'd0;
            r_addr  <= 8'd0;
            r_func  <= 8'd0;
            r_cnt   <= 8'd0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_pos   <= '0;
                r_crc   <= CRC_INIT;
                r_older <= 8'd0;
                r_newer <= 8'd0;
                r_addr  <= 8'd0;
                r_func  <= 8'd0;
                r_cnt   <= 8'd0;
            end else begin
                r_pos   <= n_pos;
                r_crc   <= n_crc;
                r_older <= n_older;
                r_newer <= n_newer;
                r_addr  <= n_addr;
                r_func  <= n_func;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

/* rtl/modbus_rtu_response_checker_top.sv */
// Top level of the Modbus RTU response checker: config port, frame logic, output register.
//
//   channel  | direction | handshake               | word
//   ---------+-----------+-------------------------+-------------------------------------
//   input    | in        | i_in_valid / o_in_stall | i_rx_byte, i_frame_end
//   result   | out       | o_out_valid/ i_out_stall| o_data_byte, o_data_valid,
//            |           |                         | o_frame_done, o_status, o_exception_code
//   config   | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// Each accepted byte yields one registered result word; one byte per cycle unless stalled.
// The CRC step and the status decode sit between the frame state and the output register.
// Reset (synchronous, active low) clears the frame state and the output register valid.
// o_in_stall is high only while a result word is held and the downstream side stalls.
module modbus_rtu_response_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_frame_done,
    output logic [3:0]  o_status,
    output logic [7:0]  o_exception_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbrc_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    in_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    mbrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbrc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_byte      = r_out.data_byte;
    assign o_data_valid     = r_out.data_valid;
    assign o_frame_done     = r_out.frame_done;
    assign o_status         = r_out.status;
    assign o_exception_code = r_out.exception_code;

endmodule

/* rtl/mbrc_checker.sv */
// Port-level assertions for the response checker, bound to the top level.
module mbrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_data_byte,
    input logic       o_data_valid,
    input logic       o_frame_done,
    input logic [3:0] o_status,
    input logic [7:0] o_exception_code
);
    import mbrc_pkg::*;

    // Mid-frame words carry no status
    a_no_status_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> (o_status == ST_OK && o_exception_code == 8'd0))
        else $error("status or exception code set on a mid-frame word");

    // Exception code only with exception status
    a_code_with_exception: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_exception_code != 8'd0) |-> (o_status == ST_EXCEPTION))
        else $error("exception code without exception status");

    // Data byte zero when not forwarded
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_data_valid) |-> (o_data_byte == 8'd0))
        else $error("data byte nonzero without data valid");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_data_byte)
            && $stable(o_status) && $stable(o_frame_done)))
        else $error("stalled result word changed");

endmodule

bind modbus_rtu_response_checker_top mbrc_checker u_mbrc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_data_byte      (o_data_byte),
    .o_data_valid     (o_data_valid),
    .o_frame_done     (o_frame_done),
    .o_status         (o_status),
    .o_exception_code (o_exception_code)
);

/* bench/modbus_rtu_response_checker_top_test.sv */
// Self-checking testbench for the Modbus RTU response checker top level.
module modbus_rtu_response_checker_top_test;
    import mbrc_pkg::*;

    // Register map and run limits
    localparam logic [2:0] REG_SLAVE_ADDR = 3'd0;
    localparam logic [2:0] REG_EXP_FUNC   = 3'd4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int NUM_PHASES      = 8;

    // Modbus function codes
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;
    localparam logic [7:0] FC_RW_MULTIPLE   = 8'd23;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
    localparam logic [7:0] EXC_FLAG         = 8'h80;

    typedef logic [7:0] t_byte_q [$];
    typedef struct packed {
        logic [7:0] rx;
        logic       last;
    } t_rx_word;

    // DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_data_valid;
    logic        o_frame_done;
    logic [3:0]  o_status;
    logic [7:0]  o_exception_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Bench state
    t_rx_word   rx_words_q [$];
    t_result    pending_results [$];
    int         queued_items = 0;
    int         err_count = 0;
    int         word_idx = 0;
    int         cycle_count = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;

    // Predictor copy of the registers and frame state
    logic [7:0]  cfg_addr = 8'd1;
    logic [6:0]  cfg_func = 7'd3;
    logic [8:0]  rx_count = '0;
    logic [15:0] crc_run = CRC_INIT;
    logic [7:0]  dly_old = '0;
    logic [7:0]  dly_new = '0;
    logic [7:0]  hdr_addr = '0;
    logic [7:0]  hdr_func = '0;
    logic [7:0]  hdr_cnt = '0;

    modbus_rtu_response_checker_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_rx_byte(i_rx_byte), .i_frame_end(i_frame_end),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_data_byte(o_data_byte), .o_data_valid(o_data_valid),
        .o_frame_done(o_frame_done), .o_status(o_status),
        .o_exception_code(o_exception_code),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic read_fc(input logic [7:0] f);
        case (f)
            FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING,
            FC_READ_INPUT, FC_RW_MULTIPLE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic write_fc(input logic [7:0] f);
        case (f)
            FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Bitwise Modbus CRC-16, LSB first
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // Advance the frame state by one byte and return the result word it yields
    function automatic t_result next_result(input logic [7:0] b, input logic last);
        t_result    r;
        logic       over;
        logic [8:0] n;
        logic [7:0] fc;
        r = '0;
        over = (rx_count >= MAX_FRAME_BYTES);
        if (!over) begin
            if (rx_count >= PAYLOAD_START && read_fc(hdr_func)) begin
                r.data_byte = dly_old;
                r.data_valid = 1'b1;
            end
            dly_old = dly_new;
            dly_new = b;
            crc_run = crc_step(crc_run, b);
            case (rx_count)
                9'd0: hdr_addr = b;
                9'd1: hdr_func = b;
                9'd2: hdr_cnt = b;
                default: ;
            endcase
            rx_count = rx_count + 9'd1;
        end
        if (last) begin
            n = rx_count;
            fc = {1'b0, hdr_func[6:0]};
            r.frame_done = 1'b1;
            if (over)
                r.status = ST_TOO_LONG;
            else if (n < MIN_FRAME_BYTES)
                r.status = ST_SHORT;
            else if (crc_run != 16'h0000)
                r.status = ST_CRC;
            else if (hdr_addr != cfg_addr)
                r.status = ST_ADDRESS;
            else if (n < MIN_PDU_FRAME_BYTES)
                r.status = ST_PDU_SHORT;
            else if (fc[6:0] != cfg_func)
                r.status = ST_FUNCTION;
            else if (hdr_func[7] && hdr_cnt != 8'h00) begin
                r.status = ST_EXCEPTION;
                r.exception_code = hdr_cnt;
            end else if (!read_fc(fc) && !write_fc(fc))
                r.status = ST_UNKNOWN;
            else if (read_fc(fc)) begin
                if (n != {1'b0, hdr_cnt} + 9'd5)
                    r.status = ST_COUNT;
            end else if (n != WRITE_FRAME_BYTES)
                r.status = ST_WRITE_SIZE;
            // frame state back to idle, registers kept
            rx_count = '0;
            crc_run = CRC_INIT;
            dly_old = '0;
            dly_new = '0;
            hdr_addr = '0;
            hdr_func = '0;
            hdr_cnt = '0;
        end
        return r;
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 8))
            0: return FC_READ_COILS;
            1: return FC_READ_DISCRETE;
            2: return FC_READ_HOLDING;
            3: return FC_READ_INPUT;
            4: return FC_RW_MULTIPLE;
            5: return FC_WRITE_COIL;
            6: return FC_WRITE_REG;
            7: return FC_WRITE_COILS;
            default: return FC_WRITE_REGS;
        endcase
    endfunction

    task automatic note_error(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    // Queue one frame, optionally with its CRC (low byte first), last byte marked
    task automatic push_frame(input t_byte_q f, input bit add_crc, input bit bad_crc);
        logic [15:0] c;
        if (add_crc) begin
            c = CRC_INIT;
            for (int i = 0; i < f.size(); i++)
                c = crc_step(c, f[i]);
            if (bad_crc)
                c = c ^ (16'h0001 << $urandom_range(0, 15));
            f.push_back(c[7:0]);
            f.push_back(c[15:8]);
        end
        for (int i = 0; i < f.size(); i++)
            rx_words_q.push_back('{rx: f[i], last: (i == f.size() - 1)});
        queued_items += f.size();
    endtask

    // Read response with n_data payload bytes, used for the size limits
    task automatic push_long_frame(input int n_data);
        t_byte_q f;
        f = {cfg_addr, FC_READ_HOLDING, 8'(n_data)};
        repeat (n_data) f.push_back(8'($urandom_range(0, 255)));
        push_frame(f, 1'b1, 1'b0);
    endtask

    // Random frame: mostly well-formed responses, some broken ones and noise
    task automatic push_random_frame();
        t_byte_q    f;
        int         kind;
        int         n;
        logic [7:0] fn;
        bit         add_crc;
        kind = $urandom_range(0, 99);
        f = {};
        f.push_back(($urandom_range(0, 9) < 8) ? cfg_addr : 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: fn = {1'b0, cfg_func};
            6, 7, 8: fn = pick_code();
            default: fn = 8'($urandom_range(0, 255));
        endcase
        add_crc = ($urandom_range(0, 19) != 0);
        if (kind < 45) begin
            // read response, occasionally with a wrong count byte
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            f.push_back(fn);
            f.push_back(($urandom_range(0, 9) == 0) ? 8'(n + $urandom_range(1, 3)) : 8'(n));
            repeat (n) f.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 65) begin
            // write echo, occasionally of the wrong size
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 4;
            f.push_back(fn);
            repeat (n) f.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 77) begin
            // exception response, sometimes with a zero code
            f.push_back(fn | EXC_FLAG);
            f.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        end else if (kind < 90) begin
            // noise
            repeat ($urandom_range(0, 10)) f.push_back(8'($urandom_range(0, 255)));
            add_crc = 1'($urandom_range(0, 1));
        end else begin
            // very short frame
            repeat ($urandom_range(0, 1)) f.push_back(8'($urandom_range(0, 255)));
            add_crc = 1'($urandom_range(0, 1));
        end
        push_frame(f, add_crc, ($urandom_range(0, 9) == 0));
    endtask

    // APB write: setup cycle then access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sender stays quiet until every expected word has come back
    task automatic wait_drained();
        while (rx_words_q.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Input driver
    always @(posedge i_clk) begin
        t_rx_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(next_result(i_rx_byte, i_frame_end));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (rx_words_q.size() != 0) begin
                    w = rx_words_q.pop_front();
                    i_rx_byte <= w.rx;
                    i_frame_end <= w.last;
                    i_in_valid <= 1'b1;
                    gap_left = pick_gap(idle_pct);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and downstream stall
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    note_error($sformatf("word %0d arrived with nothing expected", word_idx));
                end else begin
                    want = pending_results.pop_front();
                    if (o_data_byte !== want.data_byte)
                        note_error($sformatf("word %0d data_byte got %02h want %02h",
                                             word_idx, o_data_byte, want.data_byte));
                    if (o_data_valid !== want.data_valid)
                        note_error($sformatf("word %0d data_valid got %b want %b",
                                             word_idx, o_data_valid, want.data_valid));
                    if (o_frame_done !== want.frame_done)
                        note_error($sformatf("word %0d frame_done got %b want %b",
                                             word_idx, o_frame_done, want.frame_done));
                    if (o_status !== want.status)
                        note_error($sformatf("word %0d status got %0d want %0d",
                                             word_idx, o_status, want.status));
                    if (o_exception_code !== want.exception_code)
                        note_error($sformatf("word %0d exception_code got %02h want %02h",
                                             word_idx, o_exception_code, want.exception_code));
                end
                word_idx++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modbus_rtu_response_checker_top test failed");
            $finish;
        end
    end

    // Stimulus: directed frames at reset settings, then random phases
    initial begin
        logic [7:0] a;
        logic [6:0] fnc;
        int         phase_start;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 60);
            stall_pct = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 30 : 15);
            if (p != 0) begin
                a = 8'($urandom_range(0, 255));
                case (p)
                    1: begin a = 8'h00; fnc = FC_READ_COILS[6:0]; end
                    2: begin a = 8'hFF; fnc = FUNCTION_MASK; end
                    3: fnc = FC_RW_MULTIPLE[6:0];
                    4: fnc = FC_WRITE_REGS[6:0];
                    5: fnc = FC_WRITE_COIL[6:0];
                    6: fnc = 7'($urandom_range(0, 127));
                    default: begin a = 8'hFF; fnc = 7'd0; end
                endcase
                // upper data bits are junk; the register keeps only its own width
                write_reg(REG_SLAVE_ADDR, ($urandom() & 32'hFFFF_FF00) | {24'd0, a});
                cfg_addr = a;
                write_reg(REG_EXP_FUNC, ($urandom() & 32'hFFFF_FF80) | {25'd0, fnc});
                cfg_func = fnc;
            end
            phase_start = queued_items;
            if (p == 0) begin
                // one and two byte frames
                push_frame({8'h01}, 1'b0, 1'b0);
                push_frame({8'h01, FC_READ_HOLDING}, 1'b0, 1'b0);
                // address and CRC only
                push_frame({8'h01}, 1'b1, 1'b0);
                // good read with extreme payload values
                push_frame({8'h01, FC_READ_HOLDING, 8'h02, 8'h00, 8'hFF}, 1'b1, 1'b0);
                // device exception, then the flag with a zero code
                push_frame({8'h01, FC_READ_HOLDING | EXC_FLAG, 8'h02}, 1'b1, 1'b0);
                push_frame({8'h01, FC_READ_HOLDING | EXC_FLAG, 8'h00}, 1'b1, 1'b0);
                wait_drained();
                // frame of exactly the maximum size
                push_long_frame(251);
            end
            if (p == 5)
                push_long_frame($urandom_range(252, 258));
            while (queued_items - phase_start < ITEMS_PER_PHASE)
                push_random_frame();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("modbus_rtu_response_checker_top test passed");
        end else begin
            $display("modbus_rtu_response_checker_top test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mbrc_pkg.sv
rtl/mbrc_crc.sv
rtl/mbrc_regs.sv
rtl/mbrc_frame.sv
rtl/modbus_rtu_response_checker_top.sv
rtl/mbrc_checker.sv
bench/modbus_rtu_response_checker_top_test.sv
